// ===== sv/cfln_pkg.sv =====
// shared types, codes and edge/grid helper functions for the cube face led neighbor block
package cfln_pkg;

  // request kinds
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_TOWARDS = 2'd1;
  localparam logic [1:0] REQ_AWAY    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_LINK = 2'd1;
  localparam logic [1:0] ST_NO_BACK = 2'd2;

  // edges / directions, clockwise
  localparam logic [1:0] DIR_TOP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_BOTTOM = 2'd2;
  localparam logic [1:0] DIR_LEFT   = 2'd3;

  localparam logic [3:0] LED_LAST = 4'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] face;
    logic [1:0] direction;
    logic [2:0] neighbor_face;
    logic [3:0] led_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] next_face;
    logic [3:0] dest_led;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] face;
  } link_t;

  // one face: a link per edge, indexed by edge code
  typedef link_t [3:0] row_t;

  // optional 2-bit value (edge number or position along an edge)
  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } opt_idx_t;

  // result of one move on the grid: on_grid is high when the move stays on the face
  typedef struct packed {
    logic       on_grid;
    logic [3:0] led;
  } grid_step_t;

  // first edge of a face that links to face g
  function automatic opt_idx_t first_edge(input row_t row, input logic [2:0] g);
    opt_idx_t r;
    r = '0;
    for (int e = 3; e >= 0; e--) begin
      if (row[e].valid && row[e].face == g) begin
        r.hit = 1'b1;
        r.idx = 2'(e);
      end
    end
    return r;
  endfunction

  // clockwise position of an led along an edge
  function automatic opt_idx_t edge_pos(input logic [3:0] led, input logic [1:0] e);
    opt_idx_t r;
    r = '0;
    unique case (e)
      DIR_TOP: begin
        if (led < 4'd3) begin
          r.hit = 1'b1;
          r.idx = led[1:0];
        end
      end
      DIR_RIGHT: begin
        unique case (led)
          4'd2:    r = '{hit: 1'b1, idx: 2'd0};
          4'd5:    r = '{hit: 1'b1, idx: 2'd1};
          4'd8:    r = '{hit: 1'b1, idx: 2'd2};
          default: r = '0;
        endcase
      end
      DIR_BOTTOM: begin
        unique case (led)
          4'd6:    r = '{hit: 1'b1, idx: 2'd2};
          4'd7:    r = '{hit: 1'b1, idx: 2'd1};
          4'd8:    r = '{hit: 1'b1, idx: 2'd0};
          default: r = '0;
        endcase
      end
      DIR_LEFT: begin
        unique case (led)
          4'd0:    r = '{hit: 1'b1, idx: 2'd2};
          4'd3:    r = '{hit: 1'b1, idx: 2'd1};
          4'd6:    r = '{hit: 1'b1, idx: 2'd0};
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // led at clockwise position i along edge e
  function automatic logic [3:0] led_on_edge(input logic [1:0] e, input logic [1:0] i);
    logic [3:0] ii;
    logic [3:0] r;
    ii = {2'b00, i};
    unique case (e)
      DIR_TOP:    r = ii;
      DIR_RIGHT:  r = 4'd2 + (ii + ii + ii);
      DIR_BOTTOM: r = 4'd8 - ii;
      DIR_LEFT:   r = 4'd6 - (ii + ii + ii);
      default:    r = ii;
    endcase
    return r;
  endfunction

  // one move on the 3x3 grid; on_grid is low when the move leaves the face
  function automatic grid_step_t grid_step(input logic [3:0] led, input logic [1:0] dir);
    grid_step_t r;
    logic       col0;
    logic       col2;
    col0 = (led == 4'd0) || (led == 4'd3) || (led == 4'd6);
    col2 = (led == 4'd2) || (led == 4'd5) || (led == 4'd8);
    r = '0;
    unique case (dir)
      DIR_TOP:    r = '{on_grid: (led >= 4'd3), led: led - 4'd3};
      DIR_RIGHT:  r = '{on_grid: !col2,         led: led + 4'd1};
      DIR_BOTTOM: r = '{on_grid: (led <= 4'd5), led: led + 4'd3};
      DIR_LEFT:   r = '{on_grid: !col0,         led: led - 4'd1};
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cfln_link_tbl.sv =====
// face adjacency table: one link per face edge, cleared to no link at reset
module cfln_link_tbl #(
  parameter int ROWS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [2:0]                  wface_i,
  input  logic [1:0]                  wedge_i,
  input  logic [2:0]                  wlink_i,
  output cfln_pkg::row_t [ROWS-1:0]   rows_o
);
  import cfln_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  row_t [ROWS-1:0] rows_q;
  logic            wr_hit;

  // faces beyond the table take no links
  assign wr_hit = we_i && (int'(wface_i) < ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (wr_hit) begin
      rows_q[wface_i[RW-1:0]][wedge_i] <= '{valid: 1'b1, face: wlink_i};
    end
  end

  assign rows_o = rows_q;

endmodule

// ===== sv/cube_face_led_neighbor.sv =====
// top level: request register, neighbor lookup logic and result register
// usage:
//   input channel in_valid_i / in_stall_o carries one request word per handshake:
//   write link, step towards a direction, or step away from a neighbor face.
//   output channel out_valid_o / out_stall_i returns exactly one result word per
//   request (status, next face, next led), in request order.
// timing:
//   a word accepted into the request register is resolved by the lookup logic and
//   lands in the result register when that one is empty or its word is taken;
//   one request per cycle is sustained while out_stall_i is low, the path being
//   a read of the own face row and of the neighbor face row, a back-edge search over that row and a small mux.
//   a link write takes effect for the very next request.
// stall:
//   when the result register is full and out_stall_i is high, the request
//   register holds its word; a new word is still taken while that register is
//   empty, and in_stall_o rises only when both registers are full and stalled.
// reset:
//   rst_ni (async, active low) empties both registers and clears every edge of
//   the link table to no link; there is no clearing sweep, requests are taken as
//   soon as reset is released.
module cube_face_led_neighbor #(
  parameter int FACES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfln_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfln_pkg::out_word_t out_word_o
);
  import cfln_pkg::*;

  // the face field is three bits wide, so at most eight faces are addressable
  localparam int ROWS = (FACES < 8) ? FACES : 8;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  // pipeline registers
  logic      req_valid_q, req_valid_d;
  in_word_t  req_q, req_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic      out_ready;
  logic      req_adv;

  // link table
  row_t [ROWS-1:0] rows;
  logic            tbl_we;

  // lookup path
  row_t       row_f;
  row_t       row_n;
  opt_idx_t   away_edge;
  logic [1:0] step_dir;
  grid_step_t inner;
  link_t      link;
  opt_idx_t   back;
  opt_idx_t   mine;
  opt_idx_t   pos;
  logic [1:0] step_status;
  out_word_t  result;

  // handshake: result register frees when empty or taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign req_adv    = req_valid_q && out_ready;
  assign in_stall_o = req_valid_q && !out_ready;

  always_comb begin
    req_valid_d = req_valid_q;
    req_d       = req_q;
    if (!req_valid_q || out_ready) begin
      req_valid_d = in_valid_i;
      req_d       = in_word_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready) begin
      out_valid_d = req_valid_q;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  // the write lands as the request leaves, so the next request sees it
  assign tbl_we = req_adv && (req_q.req_type == REQ_WRITE);

  cfln_link_tbl #(
    .ROWS (ROWS)
  ) u_link_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .wface_i (req_q.face),
    .wedge_i (req_q.direction),
    .wlink_i (req_q.neighbor_face),
    .rows_o  (rows)
  );

  // lookup: own face row, then the row of the face across the crossed edge
  always_comb begin
    // faces beyond the table read as unlinked
    row_f = (int'(req_q.face) < ROWS) ? rows[req_q.face[RW-1:0]] : '0;

    // step away: walk towards the edge opposite the one linked to the reference
    away_edge = first_edge(row_f, req_q.neighbor_face);
    step_dir  = (req_q.req_type == REQ_AWAY) ? (away_edge.idx + 2'd2) : req_q.direction;

    inner = grid_step(req_q.led_index, step_dir);
    link  = row_f[step_dir];
    row_n = (int'(link.face) < ROWS) ? rows[link.face[RW-1:0]] : '0;
    back  = first_edge(row_n, req_q.face);
    mine  = first_edge(row_f, link.face);
    pos   = edge_pos(req_q.led_index, mine.idx);

    result = '0;
    priority if (req_q.led_index > LED_LAST) begin
      step_status = ST_NO_BACK;
    end else if (inner.on_grid) begin
      step_status      = ST_OK;
      result.next_face = req_q.face;
      result.dest_led  = inner.led;
    end else if (!link.valid) begin
      step_status = ST_NO_LINK;
    end else if (!back.hit || !mine.hit || !pos.hit) begin
      // no back edge, or the led is not on the first edge linked to the neighbor
      step_status = ST_NO_BACK;
    end else begin
      step_status      = ST_OK;
      result.next_face = link.face;
      result.dest_led  = led_on_edge(back.idx, 2'd2 - pos.idx);
    end

    unique case (req_q.req_type)
      REQ_TOWARDS: result.status = step_status;
      REQ_AWAY: begin
        if (!away_edge.hit) begin
          result.status = ST_NO_LINK;
        end else begin
          result.status = step_status;
        end
      end
      default: result.status = ST_OK;  // link write and unused request code
    endcase

    // any error or non-step request returns zero face and led
    if (result.status != ST_OK ||
        (req_q.req_type != REQ_TOWARDS && req_q.req_type != REQ_AWAY)) begin
      result.next_face = '0;
      result.dest_led  = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // backpressure only when a request is actually held
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_valid_q)
    else $error("input stalled with empty request register");

  // a held request keeps its contents until it moves on
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !out_ready) |=> (req_valid_q && $stable(req_q)))
    else $error("held request changed");

  // a link write answers ok with zero face and led
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_adv && req_q.req_type == REQ_WRITE) |=>
      (out_valid_q && out_q.status == ST_OK && out_q.next_face == 3'd0 &&
       out_q.dest_led == 4'd0))
    else $error("link write gave a non-zero result");

  // error results carry zero face and led
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |->
      (out_q.next_face == 3'd0 && out_q.dest_led == 4'd0))
    else $error("error result with non-zero payload");
`endif

endmodule
